// File: rtl/joystick_to_differential_drive_macros.svh
// Assertion macros for the joystick mixer.
`ifndef JOYSTICK_TO_DIFFERENTIAL_DRIVE_MACROS_SVH
`define JOYSTICK_TO_DIFFERENTIAL_DRIVE_MACROS_SVH

`ifndef SYNTHESIS
`define JDD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JDD_ASSERT_IMPL(label, ante, cons, msg)
`define JDD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/jdd_pkg.sv
// Shared types, constants and elaboration-time tables for the joystick mixer.
package jdd_pkg;

    localparam int SIN_W = 41;
    localparam int OUT_W = 32;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_DIV = PI_Q60 / 180;
    localparam logic [63:0] PI_MOD = PI_Q60 % 180;

    typedef logic [90:0][SIN_W-1:0] sin_tab_t;
    typedef logic [88:0][7:0] slope_tab_t;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_BACK = 2'd2,
        DRV_HOLD = 2'd3
    } drive_t;

    // long division, only used while building the tables
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], a[b]};
            if (r >= d)
            begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] trig_q60(input int k, input bit want_cos);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        bit neg;
        x = PI_DIV * 64'(k) + div_u64(PI_MOD * 64'(k), 64'd180);
        x2 = mul_q60(x, x);
        term = want_cos ? (64'd1 << 60) : x;
        sum = term;
        n = want_cos ? 64'd1 : 64'd2;
        neg = 1'b1;
        while (term != 64'd0)
        begin
            term = div_u64(mul_q60(term, x2), n * (n + 64'd1));
            n = n + 64'd2;
            if (neg)
                sum = sum - term;
            else
                sum = sum + term;
            neg = !neg;
        end
        return sum;
    endfunction

    function automatic logic [SIN_W-1:0] to_q40(input logic [63:0] v);
        logic [63:0] t;
        t = (v + (64'd1 << 19)) >> 20;
        return t[SIN_W-1:0];
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t t;
        t = '0;
        for (int k = 0; k <= 45; k++)
            t[k] = to_q40(trig_q60(k, 1'b0));
        for (int k = 0; k < 45; k++)
            t[90-k] = to_q40(trig_q60(k, 1'b1));
        return t;
    endfunction

    function automatic slope_tab_t build_slope_tab();
        slope_tab_t t;
        for (int k = 0; k <= 88; k++)
            t[k] = 8'(k * 255 / 88);
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();
    localparam slope_tab_t SLOPE_TAB = build_slope_tab();

    // floor(n / 100) for n below 43000, by reciprocal
    function automatic logic [8:0] div100(input logic [15:0] n);
        logic [29:0] p;
        p = 30'(n) * 30'd5243;
        return p[27:19];
    endfunction

endpackage

// File: rtl/joystick_to_differential_drive.sv
// Joystick sample to differential-drive duties, heading and drive code.
//
//  channel | dir | tdata fields (low bit first)
//  s_*     | in  | stick_x[AXIS_BITS], stick_y[AXIS_BITS], zero fill to bytes
//  m_*     | out | left_duty[8], right_duty[8], drive[2], heading[9], 5 zero
//
// One word per cycle while m_tready does not stall the chain.
// Each heading bit is one binary-search step against the sine table and each
// root bit one digit of the square root, both in the shared stage chain.
// rst_n clears the valid bits only; stalls freeze the whole chain, nothing dropped.
`include "joystick_to_differential_drive_macros.svh"

module joystick_to_differential_drive #(
    parameter int AXIS_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((2*AXIS_BITS+7)/8)*8-1:0] s_tdata,  // stick_x, stick_y
    output logic m_tvalid,
    input  logic m_tready,
    output logic [jdd_pkg::OUT_W-1:0] m_tdata        // left, right, drive, heading
);
    import jdd_pkg::*;

    localparam int NS = (AXIS_BITS > 8) ? AXIS_BITS : 8;
    localparam int PW = AXIS_BITS + SIN_W + 2;

    typedef enum logic [2:0] {
        SEC_EDGE, SEC_Q1, SEC_AXIS, SEC_Q2, SEC_WEST, SEC_Q3, SEC_Q4
    } sector_t;

    logic adv;

    logic                        vld_reg   [0:NS];
    logic signed [AXIS_BITS-1:0] dx_reg    [0:NS];
    logic [AXIS_BITS-1:0]        ay_reg    [0:NS];
    logic                        dyneg_reg [0:NS];
    logic [2*AXIS_BITS-1:0]      sq_reg    [0:NS];
    logic [AXIS_BITS+1:0]        rem_reg   [0:NS];
    logic [AXIS_BITS-1:0]        root_reg  [0:NS];
    logic [7:0]                  lo_reg    [0:NS];

    // ---- entry stage: centre, magnitude of y, sum of squares
    logic [AXIS_BITS-1:0]        in_x, in_y;
    logic signed [AXIS_BITS-1:0] dx_next, dy_next;
    logic [AXIS_BITS-1:0]        ay_next;
    logic signed [2*AXIS_BITS-1:0] sqx, sqy;
    logic [2*AXIS_BITS-1:0]      sq_next;

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        in_x = s_tdata[AXIS_BITS-1:0];
        in_y = s_tdata[2*AXIS_BITS-1:AXIS_BITS];
        dx_next = $signed({~in_x[AXIS_BITS-1], in_x[AXIS_BITS-2:0]});
        dy_next = $signed({~in_y[AXIS_BITS-1], in_y[AXIS_BITS-2:0]});
        ay_next = dy_next[AXIS_BITS-1] ? (~dy_next + 1'b1) : dy_next;
        sqx = dx_next * dx_next;
        sqy = dy_next * dy_next;
        sq_next = sqx + sqy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0]    <= dx_next;
            ay_reg[0]    <= ay_next;
            dyneg_reg[0] <= dy_next[AXIS_BITS-1];
            sq_reg[0]    <= sq_next;
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
            lo_reg[0]    <= '0;
        end
    end

    // ---- iteration stages: up to one search bit and one root digit each
    for (genvar i = 1; i <= NS; i++)
    begin : g_stage
        localparam int B = 8 - i;
        localparam int J = AXIS_BITS - i;
        logic [7:0]           lo_next;
        logic [AXIS_BITS+1:0] rem_next;
        logic [AXIS_BITS-1:0] root_next;

        if (i <= 8)
        begin : g_search
            logic [7:0] cand;
            logic [6:0] si, ci;
            logic cneg;
            logic [SIN_W-1:0] sinm, cosm;
            logic [AXIS_BITS+SIN_W-1:0] pa;
            logic signed [AXIS_BITS+SIN_W:0] pb;
            logic signed [PW-1:0] t1, t2, dif;

            always_comb
            begin
                cand = lo_reg[i-1] | (8'd1 << B);
                cneg = 1'b0;
                if (cand > 8'd180)
                begin
                    si = '0;
                    ci = '0;
                end
                else if (cand <= 8'd90)
                begin
                    si = cand[6:0];
                    ci = 7'(8'd90 - cand);
                end
                else
                begin
                    si = 7'(8'd180 - cand);
                    ci = 7'(cand - 8'd90);
                    cneg = 1'b1;
                end
                sinm = SIN_TAB[si];
                cosm = SIN_TAB[ci];
                pa = ay_reg[i-1] * cosm;
                pb = dx_reg[i-1] * $signed({1'b0, sinm});
                t1 = $signed(PW'(pa));
                t2 = PW'(pb);
                dif = (cneg ? -t1 : t1) - t2;
                // predicate is monotone in the candidate, so keep the largest true one
                lo_next = (cand <= 8'd180 && !dif[PW-1]) ? cand : lo_reg[i-1];
            end
        end
        else
        begin : g_nosearch
            assign lo_next = lo_reg[i-1];
        end

        if (i <= AXIS_BITS)
        begin : g_root
            logic [AXIS_BITS+3:0] sh, tr;

            always_comb
            begin
                sh = {rem_reg[i-1], sq_reg[i-1][2*J+1 -: 2]};
                tr = (AXIS_BITS+4)'({root_reg[i-1], 2'b01});
                if (sh >= tr)
                begin
                    rem_next = (AXIS_BITS+2)'(sh - tr);
                    root_next = {root_reg[i-1][AXIS_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = (AXIS_BITS+2)'(sh);
                    root_next = {root_reg[i-1][AXIS_BITS-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_noroot
            assign rem_next = rem_reg[i-1];
            assign root_next = root_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (adv)
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dx_reg[i]    <= dx_reg[i-1];
                ay_reg[i]    <= ay_reg[i-1];
                dyneg_reg[i] <= dyneg_reg[i-1];
                sq_reg[i]    <= sq_reg[i-1];
                rem_reg[i]   <= rem_next;
                root_reg[i]  <= root_next;
                lo_reg[i]    <= lo_next;
            end
        end
    end

    // ---- heading, speed and drive code
    logic       e_vld_reg;
    logic [8:0] e_pos_reg, e_pos_next;
    logic [7:0] e_s_reg, e_s_next;
    drive_t     e_drive_reg, e_drive_next;
    logic [7:0] deg;
    logic       centre, on_x;
    logic [AXIS_BITS+6:0] r100;

    always_comb
    begin
        on_x = (ay_reg[NS] == '0);
        centre = on_x && (dx_reg[NS] == '0);
        if (on_x)
            deg = dx_reg[NS][AXIS_BITS-1] ? 8'd180 : 8'd0;
        else
            deg = lo_reg[NS];
        if (centre)
            e_pos_next = 9'd0;
        else if (dyneg_reg[NS])
            e_pos_next = 9'd360 - {1'b0, deg};
        else
            e_pos_next = {1'b0, deg};
        r100 = (AXIS_BITS+7)'(root_reg[NS]) * (AXIS_BITS+7)'(100);
        e_s_next = 8'(r100 >> (AXIS_BITS - 1));
        if (centre)
            e_drive_next = DRV_STOP;
        else if (dyneg_reg[NS])
            e_drive_next = DRV_BACK;
        else if (on_x)
            e_drive_next = DRV_HOLD;
        else
            e_drive_next = DRV_FWD;
    end

    // ---- sector, full-scale duty and ramp product
    logic       f_vld_reg;
    sector_t    f_sec_reg, f_sec_next;
    logic [8:0] f_full_reg, f_full_next;
    logic [15:0] f_prod_reg, f_prod_next;
    logic [8:0] f_pos_reg;
    drive_t     f_drive_reg;
    logic [8:0] base;
    logic [6:0] idx;
    logic [7:0] slope;

    always_comb
    begin
        base = 9'd0;
        if (e_pos_reg == 9'd0 || e_pos_reg == 9'd360)
            f_sec_next = SEC_EDGE;
        else if (e_pos_reg inside {[9'd1:9'd89]})
        begin
            f_sec_next = SEC_Q1;
            base = 9'd1;
        end
        else if (e_pos_reg == 9'd90 || e_pos_reg == 9'd270)
            f_sec_next = SEC_AXIS;
        else if (e_pos_reg inside {[9'd91:9'd179]})
        begin
            f_sec_next = SEC_Q2;
            base = 9'd91;
        end
        else if (e_pos_reg == 9'd180)
            f_sec_next = SEC_WEST;
        else if (e_pos_reg inside {[9'd181:9'd269]})
        begin
            f_sec_next = SEC_Q3;
            base = 9'd181;
        end
        else
        begin
            f_sec_next = SEC_Q4;
            base = 9'd271;
        end
        idx = (base == 9'd0) ? 7'd0 : 7'(e_pos_reg - base);
        slope = SLOPE_TAB[idx];
        f_full_next = div100(16'(e_s_reg) * 16'd255);
        f_prod_next = 16'(e_s_reg) * 16'(8'd255 - slope);
    end

    // ---- duty select and saturation into the output register
    logic       out_vld_reg;
    logic [7:0] out_left_reg, out_right_reg;
    logic [8:0] out_head_reg;
    drive_t     out_drive_reg;
    logic [7:0] out_left_next, out_right_next;
    logic signed [17:0] ramp_n;
    logic [8:0] ramp_v, lin_v, left_w, right_w;

    always_comb
    begin
        ramp_n = $signed(18'(f_full_reg) * 18'd100) - $signed(18'(f_prod_reg));
        ramp_v = ramp_n[17] ? 9'd0 : div100(ramp_n[15:0]);
        lin_v = div100(f_prod_reg);
        case (f_sec_reg)
            SEC_EDGE:
            begin
                left_w = f_full_reg;
                right_w = 9'd0;
            end
            SEC_Q1:
            begin
                left_w = f_full_reg;
                right_w = ramp_v;
            end
            SEC_AXIS:
            begin
                left_w = f_full_reg;
                right_w = f_full_reg;
            end
            SEC_Q2:
            begin
                left_w = lin_v;
                right_w = f_full_reg;
            end
            SEC_WEST:
            begin
                left_w = 9'd0;
                right_w = f_full_reg;
            end
            SEC_Q3:
            begin
                left_w = ramp_v;
                right_w = f_full_reg;
            end
            SEC_Q4:
            begin
                left_w = f_full_reg;
                right_w = lin_v;
            end
            default:
            begin
                left_w = 9'd0;
                right_w = 9'd0;
            end
        endcase
        out_left_next = left_w[8] ? 8'd255 : left_w[7:0];
        out_right_next = right_w[8] ? 8'd255 : right_w[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_vld_reg   <= vld_reg[NS];
            f_vld_reg   <= e_vld_reg;
            out_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_pos_reg     <= e_pos_next;
            e_s_reg       <= e_s_next;
            e_drive_reg   <= e_drive_next;
            f_sec_reg     <= f_sec_next;
            f_full_reg    <= f_full_next;
            f_prod_reg    <= f_prod_next;
            f_pos_reg     <= e_pos_reg;
            f_drive_reg   <= e_drive_reg;
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
            out_head_reg  <= f_pos_reg;
            out_drive_reg <= f_drive_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {5'd0, out_head_reg, out_drive_reg, out_right_reg, out_left_reg};

    `JDD_ASSERT_IMPL(a_stop_zero, out_vld_reg && out_drive_reg == DRV_STOP, out_left_reg == 8'd0 && out_right_reg == 8'd0 && out_head_reg == 9'd0, "stop word with nonzero duty or heading")
    `JDD_ASSERT_IMPL(a_hold_axis, out_vld_reg && out_drive_reg == DRV_HOLD, out_head_reg == 9'd0 || out_head_reg == 9'd180, "hold word off the x axis")
    `JDD_ASSERT_IMPL(a_back_half, out_vld_reg && out_drive_reg == DRV_BACK, out_head_reg >= 9'd180, "backward word with upper-half heading")
    `JDD_ASSERT_NEXT(a_valid_moves, f_vld_reg && adv, out_vld_reg, "word lost entering output register")

endmodule
